>>> design/multichannel_latching_pulse_timer_defines.svh
// Assertion macros for the multichannel latching pulse timer.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef MULTICHANNEL_LATCHING_PULSE_TIMER_DEFINES_SVH
`define MULTICHANNEL_LATCHING_PULSE_TIMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MLPT_ASSERT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MLPT_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/mlpt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the multichannel latching pulse timer.
// No dependencies.
package mlpt_pkg;

  localparam int MASK_W    = 8;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 32;
  localparam int PMS_W     = 10;
  localparam int LOCK_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CMD_W     = 2;
  localparam int IDX_W     = 4;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_PULSE  = 2'd1,
    CMD_STATUS = 2'd2
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_MS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_MASK  = 2'd2;

  localparam logic [PMS_W-1:0]  PULSE_MIN = 10'd100;
  localparam logic [PMS_W-1:0]  PULSE_MAX = 10'd1000;
  localparam logic [PMS_W-1:0]  PULSE_RST = 10'd500;
  localparam logic [LOCK_W-1:0] LOCK_RST  = 16'd300;
  localparam logic [MASK_W-1:0] CONN_RST  = 8'hFF;

  // Per-channel record: time of last accepted pulse request (also pulse start)
  // and the wrapping pulse count.
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [CNT_W-1:0]  count;
  } chan_rec_t;

endpackage

>>> design/mlpt_chan_mem.sv
`timescale 1ns / 1ps
// Per-channel record memory: one write port, one registered read port.
// Entries read as zero until first written. Depends on mlpt_pkg.
module mlpt_chan_mem #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 rd_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr_i,
  output mlpt_pkg::chan_rec_t                  rd_rec_o,
  input  logic                                 wr_en_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] wr_addr_i,
  input  mlpt_pkg::chan_rec_t                  wr_rec_i
);

  mlpt_pkg::chan_rec_t mem_q [CHANNELS];
  mlpt_pkg::chan_rec_t rd_rec_q;
  logic [CHANNELS-1:0] vld_q;
  logic                rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_rec_i;
    end
    if (rd_en_i) begin
      rd_rec_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  // Unwritten entries read as zero through their valid bits.
  assign rd_rec_o = rd_vld_q ? rd_rec_q : '0;

endmodule

>>> design/multichannel_latching_pulse_timer.sv
`timescale 1ns / 1ps
// Multichannel latching pulse timer. An accepted tick sweeps the channel records in S_TICK
// (one channel record read per cycle), a pulse request or status read passes S_LOOK (read,
// then evaluate and write back), a bad index or unused command goes straight to S_OUT, where
// the result waits until the output register is free. One item at a time: the next item is
// taken the cycle after the result enters the output register.
// Reset clears time, running and open bits, and marks all records zero. Uses mlpt_pkg.
`include "multichannel_latching_pulse_timer_defines.svh"

module multichannel_latching_pulse_timer #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [3:0] channel_index, [7:4] zero
  input  logic [mlpt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] cmd
  input  logic [mlpt_pkg::CMD_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] accepted, [8:1] drive_mask, [16:9] open_mask, [24:17] active_mask,
  // [32:25] changed_mask, [64:33] pulse_total, [71:65] zero
  output logic [mlpt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [mlpt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mlpt_pkg::CFG_W-1:0]          cfg_wdata_i
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW-1:0] CH_LAST = AW'(CHANNELS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TICK,
    S_LOOK,
    S_OUT
  } state_e;

  state_e                          state_q;
  logic [mlpt_pkg::CMD_W-1:0]      cmd_q;
  logic [AW-1:0]                   idx_q;
  logic [AW-1:0]                   ch_q;
  logic [mlpt_pkg::TIME_W-1:0]     time_q;
  logic [CHANNELS-1:0]             running_q;
  logic [CHANNELS-1:0]             open_q;
  logic [CHANNELS-1:0]             changed_q;
  logic                            acc_q;
  logic [mlpt_pkg::CNT_W-1:0]      total_q;
  logic                            out_valid_q;
  logic [mlpt_pkg::OUT_DATA_W-1:0] out_data_q;

  logic [mlpt_pkg::PMS_W-1:0]      pulse_ms_q;
  logic [mlpt_pkg::LOCK_W-1:0]     lockout_q;
  logic [mlpt_pkg::MASK_W-1:0]     conn_q;
  logic [mlpt_pkg::PMS_W-1:0]      pulse_ms_d;

  logic [mlpt_pkg::CMD_W-1:0]      in_cmd;
  logic [mlpt_pkg::IDX_W-1:0]      in_idx;
  logic                            in_idx_ok;
  logic                            in_accept;
  logic                            out_free;

  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  mlpt_pkg::chan_rec_t             rd_rec;
  logic                            wr_en;
  mlpt_pkg::chan_rec_t             wr_rec;

  logic [mlpt_pkg::TIME_W-1:0]     elapsed;
  logic                            tick_end;
  logic                            cmd_ok;
  logic [mlpt_pkg::CNT_W-1:0]      count_inc;

  logic [mlpt_pkg::MASK_W-1:0]     run_w;
  logic [mlpt_pkg::MASK_W-1:0]     open_w;
  logic [mlpt_pkg::MASK_W-1:0]     changed_w;

  // Configuration registers
  always_comb begin
    pulse_ms_d = cfg_wdata_i[mlpt_pkg::PMS_W-1:0];
    if (pulse_ms_d < mlpt_pkg::PULSE_MIN) begin
      pulse_ms_d = mlpt_pkg::PULSE_MIN;
    end else if (pulse_ms_d > mlpt_pkg::PULSE_MAX) begin
      pulse_ms_d = mlpt_pkg::PULSE_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_ms_q <= mlpt_pkg::PULSE_RST;
      lockout_q  <= mlpt_pkg::LOCK_RST;
      conn_q     <= mlpt_pkg::CONN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mlpt_pkg::REG_PULSE_MS:   pulse_ms_q <= pulse_ms_d;
        mlpt_pkg::REG_LOCKOUT_MS: lockout_q  <= cfg_wdata_i[mlpt_pkg::LOCK_W-1:0];
        mlpt_pkg::REG_CONN_MASK:  conn_q     <= cfg_wdata_i[mlpt_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input decode
  assign in_cmd        = s_axis_tuser;
  assign in_idx        = s_axis_tdata[mlpt_pkg::IDX_W-1:0];
  assign in_idx_ok     = 32'(in_idx) < CHANNELS;
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Memory read: the indexed channel on a request; channel 0, then one ahead, on a tick.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_q == S_IDLE && in_accept) begin
      if (in_cmd == mlpt_pkg::CMD_TICK) begin
        rd_en = 1'b1;
      end else if ((in_cmd == mlpt_pkg::CMD_PULSE || in_cmd == mlpt_pkg::CMD_STATUS)
                   && in_idx_ok) begin
        rd_en   = 1'b1;
        rd_addr = in_idx[AW-1:0];
      end
    end else if (state_q == S_TICK) begin
      rd_en   = (ch_q != CH_LAST);
      rd_addr = ch_q + 1'b1;
    end
  end

  assign elapsed   = time_q - rd_rec.stamp;
  assign tick_end  = running_q[ch_q] &&
                     (elapsed >= mlpt_pkg::TIME_W'(pulse_ms_q));
  assign cmd_ok    = !running_q[idx_q] &&
                     (elapsed >= mlpt_pkg::TIME_W'(lockout_q));
  assign count_inc = rd_rec.count + 1'b1;

  assign wr_en        = (state_q == S_LOOK) && (cmd_q == mlpt_pkg::CMD_PULSE) && cmd_ok;
  assign wr_rec.stamp = time_q;
  assign wr_rec.count = count_inc;

  mlpt_chan_mem #(
    .CHANNELS (CHANNELS)
  ) u_chan_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_rec_o  (rd_rec),
    .wr_en_i   (wr_en),
    .wr_addr_i (idx_q),
    .wr_rec_i  (wr_rec)
  );

  // Widen channel masks to the port width; unused channels read zero.
  always_comb begin
    run_w     = '0;
    open_w    = '0;
    changed_w = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      run_w[i]     = running_q[i];
      open_w[i]    = open_q[i];
      changed_w[i] = changed_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      idx_q       <= '0;
      ch_q        <= '0;
      time_q      <= '0;
      running_q   <= '0;
      open_q      <= '0;
      changed_q   <= '0;
      acc_q       <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // S_OUT refills the output register itself when it is free.
      if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            cmd_q     <= in_cmd;
            idx_q     <= in_idx[AW-1:0];
            ch_q      <= '0;
            changed_q <= '0;
            acc_q     <= 1'b0;
            total_q   <= '0;
            if (in_cmd == mlpt_pkg::CMD_TICK) begin
              time_q  <= time_q + 1'b1;
              state_q <= S_TICK;
            end else if ((in_cmd == mlpt_pkg::CMD_PULSE ||
                          in_cmd == mlpt_pkg::CMD_STATUS) && in_idx_ok) begin
              state_q <= S_LOOK;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_TICK: begin
          if (tick_end) begin
            running_q[ch_q] <= 1'b0;
            open_q[ch_q]    <= !open_q[ch_q];
            changed_q[ch_q] <= 1'b1;
          end
          if (ch_q == CH_LAST) begin
            state_q <= S_OUT;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
        S_LOOK: begin
          if (cmd_q == mlpt_pkg::CMD_PULSE) begin
            if (cmd_ok) begin
              running_q[idx_q] <= 1'b1;
              changed_q[idx_q] <= 1'b1;
              acc_q            <= 1'b1;
              total_q          <= count_inc;
            end else begin
              total_q <= rd_rec.count;
            end
          end else begin
            acc_q   <= 1'b1;
            total_q <= rd_rec.count;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          // Hold the result until the output register is free.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {7'b0, total_q, changed_w, run_w, open_w,
                            run_w & conn_q, acc_q};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `MLPT_ASSERT(a_no_write_in_sweep, state_q == S_TICK, !wr_en,
    "record written during tick sweep")
  `MLPT_ASSERT_NEXT(a_start_runs, wr_en, running_q != '0,
    "accepted request left no pulse running")
  `MLPT_ASSERT(a_start_one_change,
    state_q == S_OUT && acc_q && cmd_q == mlpt_pkg::CMD_PULSE, $onehot(changed_q),
    "accepted request must change exactly one channel")

endmodule
